[rtl/core/assert_macros.svh]
// Assertion macros shared by the line stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define LPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define LPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/lps_pkg.sv]
// Package for the line stepper: widths, codes, states and control structs.
package lps_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS + 2;
  localparam int NUM_BITS   = 2 * COORD_BITS + 4;
  localparam int DIV_STEPS  = COORD_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } lps_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ORG,
    ST_MUL_OFF,
    ST_SUM,
    ST_DIV,
    ST_EMIT_START,
    ST_EMIT_STEP
  } lps_state_e;

  typedef struct packed {
    logic accept_start;
    logic accept_step;
    logic mul_org;
    logic mul_off;
    logic sum_load;
    logic div_step;
    logic emit_start;
    logic emit_step;
  } lps_ctrl_t;

  typedef struct packed {
    logic line_active;
    logic out_free;
  } lps_status_t;

endpackage

[rtl/core/line_pixel_stepper.sv]
// Top level of the line stepper: sequencer plus datapath.
//
//  port group   dir  handshake              payload
//  in_*         in   in_valid_i/in_ready_o  command_i, start_x_i, start_y_i, end_x_i, end_y_i
//  out_*        out  out_valid_o/out_ready_i pixel_x_o, pixel_y_o, color_out_o, last_pixel_o
//  cfg_*        in   cfg_valid_i/cfg_ready_o cfg_pixel_color_i
//
// A start word gives its first pixel once the output register is free; a step word first takes
// two passes through the shared multiplier, one add and a serial divider, then waits the same way.
// A step word with no active line is taken and gives no word.
// One input word is in flight at a time; the output register lets the next word be taken
// while a pixel still waits. Reset clears the line and the colour to zero.
module line_pixel_stepper import lps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COLOR_BITS-1:0] cfg_pixel_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0] color_out_o,
  output logic                  last_pixel_o
);

  lps_ctrl_t   ctrl;
  lps_status_t status;

  assign cfg_ready_o = 1'b1;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  lps_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_pixel_color_i (cfg_pixel_color_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pixel_x_o         (pixel_x_o),
    .pixel_y_o         (pixel_y_o),
    .color_out_o       (color_out_o),
    .last_pixel_o      (last_pixel_o)
  );

endmodule

[rtl/core/lps_ctrl.sv]
// Sequencer for the line stepper: accepts words and steps the datapath.
`include "assert_macros.svh"

module lps_ctrl import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  lps_status_t status_i,
  output lps_ctrl_t   ctrl_o
);

  lps_state_e          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == CMD_START) begin
            ctrl_o.accept_start = 1'b1;
            state_d             = ST_EMIT_START;
          end else if (status_i.line_active) begin
            ctrl_o.accept_step = 1'b1;
            state_d            = ST_MUL_ORG;
          end
        end
      end
      ST_MUL_ORG: begin
        ctrl_o.mul_org = 1'b1;
        state_d        = ST_MUL_OFF;
      end
      ST_MUL_OFF: begin
        ctrl_o.mul_off = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.sum_load = 1'b1;
        cnt_d           = CNT_BITS'(DIV_STEPS - 1);
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_EMIT_STEP;
        end
      end
      ST_EMIT_START: begin
        if (status_i.out_free) begin
          ctrl_o.emit_start = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_EMIT_STEP: begin
        if (status_i.out_free) begin
          ctrl_o.emit_step = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LPS_ASSERT_IMP(a_emit_slot_free, ctrl_o.emit_start || ctrl_o.emit_step, status_i.out_free, "emit with output register occupied")
  `LPS_ASSERT(a_div_to_emit, (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_EMIT_STEP && !in_ready_o), "division did not end in emit")
  `LPS_ASSERT_IMP(a_ready_only_idle, in_ready_o, state_q == ST_IDLE, "input ready outside idle")

endmodule

[rtl/core/lps_dpath.sv]
// Datapath for the line stepper: line state, shared multiplier, serial divider, output register.
`include "assert_macros.svh"

module lps_dpath import lps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lps_ctrl_t             ctrl_i,
  output lps_status_t           status_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  cfg_valid_i,
  input  logic [COLOR_BITS-1:0] cfg_pixel_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0] color_out_o,
  output logic                  last_pixel_o
);

  localparam int W = COORD_BITS;

  // configuration
  logic [COLOR_BITS-1:0] color_q;

  // line state
  logic                  line_active_q;
  logic                  major_is_y_q;
  logic [W-1:0]          origin_major_q, origin_minor_q, final_major_q, current_major_q;
  logic [W-1:0]          major_delta_q;
  logic signed [W:0]     minor_delta_q;

  // arithmetic
  logic signed [PROD_BITS-1:0] prod_q, acc_q;
  logic                        num_pos_q;
  logic [W:0]                  rem_q;
  logic [W-1:0]                quo_q;

  // output register
  logic                  out_valid_q;
  logic [W-1:0]          px_q, py_q;
  logic [COLOR_BITS-1:0] col_q;
  logic                  last_q;

  // start decode
  logic signed [W:0] dx_c, dy_c;
  logic [W:0]        adx_c, ady_c;
  logic              maj_y_c, swap_c;
  logic [W-1:0]      a1_c, b1_c, a2_c, b2_c;
  logic [W-1:0]      am_c, bm_c, af_c, bf_c;

  assign dx_c  = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy_c  = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign adx_c = dx_c[W] ? (W+1)'(0) - dx_c : dx_c;
  assign ady_c = dy_c[W] ? (W+1)'(0) - dy_c : dy_c;
  assign maj_y_c = ady_c > adx_c;
  assign a1_c = maj_y_c ? start_y_i : start_x_i;
  assign b1_c = maj_y_c ? start_x_i : start_y_i;
  assign a2_c = maj_y_c ? end_y_i   : end_x_i;
  assign b2_c = maj_y_c ? end_x_i   : end_y_i;
  assign swap_c = a1_c > a2_c;
  assign am_c = swap_c ? a2_c : a1_c;
  assign bm_c = swap_c ? b2_c : b1_c;
  assign af_c = swap_c ? a1_c : a2_c;
  assign bf_c = swap_c ? b1_c : b2_c;

  // shared multiplier
  logic [W-1:0]                offset_c;
  logic signed [W:0]           op_a_c, op_b_c;
  logic signed [PROD_BITS-1:0] prod_c;

  assign offset_c = current_major_q - origin_major_q;
  assign op_a_c   = ctrl_i.mul_org ? $signed({1'b0, origin_minor_q}) : $signed({1'b0, offset_c});
  assign op_b_c   = ctrl_i.mul_org ? $signed({1'b0, major_delta_q}) : minor_delta_q;
  assign prod_c   = op_a_c * op_b_c;

  // numerator 2*(om*Md + off*md) + Md
  logic [NUM_BITS-1:0] sum_c, num_c;

  assign sum_c = {{(NUM_BITS-PROD_BITS){acc_q[PROD_BITS-1]}}, acc_q}
               + {{(NUM_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
  assign num_c = {sum_c[NUM_BITS-2:0], 1'b0} + {{(NUM_BITS-W){1'b0}}, major_delta_q};

  // restoring division by 2*Md, one quotient bit a cycle
  logic [W+1:0] trial_c, dvs_c, diff_c;
  logic         ge_c;

  assign trial_c = {rem_q, quo_q[W-1]};
  assign dvs_c   = {1'b0, major_delta_q, 1'b0};
  assign diff_c  = trial_c - dvs_c;
  assign ge_c    = trial_c >= dvs_c;

  // pixel to emit
  logic [W-1:0] emit_maj_c, emit_min_c;
  logic         emit_last_c;
  logic         load_c;

  always_comb begin
    if (ctrl_i.emit_start) begin
      emit_maj_c  = origin_major_q;
      emit_min_c  = origin_minor_q;
      emit_last_c = !line_active_q;
    end else begin
      emit_maj_c  = current_major_q;
      emit_min_c  = num_pos_q ? quo_q : '0;
      emit_last_c = current_major_q == final_major_q;
    end
  end

  assign load_c = ctrl_i.emit_start || ctrl_i.emit_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q       <= '0;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_pixel_color_i;
      end
      if (ctrl_i.accept_start) begin
        line_active_q <= af_c != am_c;
      end else if (ctrl_i.emit_step && emit_last_c) begin
        line_active_q <= 1'b0;
      end
      if (load_c) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept_start) begin
      major_is_y_q    <= maj_y_c;
      origin_major_q  <= am_c;
      origin_minor_q  <= bm_c;
      final_major_q   <= af_c;
      major_delta_q   <= af_c - am_c;
      minor_delta_q   <= $signed({1'b0, bf_c}) - $signed({1'b0, bm_c});
      current_major_q <= am_c;
    end else if (ctrl_i.accept_step) begin
      current_major_q <= current_major_q + 1'b1;
    end
    if (ctrl_i.mul_org) begin
      prod_q <= prod_c;
    end
    if (ctrl_i.mul_off) begin
      acc_q  <= prod_q;
      prod_q <= prod_c;
    end
    if (ctrl_i.sum_load) begin
      num_pos_q <= !num_c[NUM_BITS-1] && (num_c != '0);
      rem_q     <= num_c[2*W:W];
      quo_q     <= num_c[W-1:0];
    end else if (ctrl_i.div_step) begin
      rem_q <= ge_c ? diff_c[W:0] : trial_c[W:0];
      quo_q <= {quo_q[W-2:0], ge_c};
    end
    if (load_c) begin
      px_q   <= major_is_y_q ? emit_min_c : emit_maj_c;
      py_q   <= major_is_y_q ? emit_maj_c : emit_min_c;
      col_q  <= color_q;
      last_q <= emit_last_c;
    end
  end

  assign status_o.line_active = line_active_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign color_out_o  = col_q;
  assign last_pixel_o = last_q;

  `LPS_ASSERT_IMP(a_major_in_range, line_active_q, current_major_q <= final_major_q, "current major beyond final endpoint")
  `LPS_ASSERT_IMP(a_delta_nonzero, line_active_q, major_delta_q != '0, "active line with zero major delta")
  `LPS_ASSERT_IMP(a_num_positive, ctrl_i.div_step, num_pos_q, "line equation numerator not positive")

endmodule

[tb/tb.sv]
// Self-checking testbench for the line pixel stepper: directed and random lines, colour changes.
module tb;
  import lps_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] colour_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    colour_t colour;
    logic    last;
  } pixel_t;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 24;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  command_i = CMD_START;
  coord_t                start_x_i = '0;
  coord_t                start_y_i = '0;
  coord_t                end_x_i = '0;
  coord_t                end_y_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  colour_t               cfg_pixel_color_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  coord_t                pixel_x_o;
  coord_t                pixel_y_o;
  colour_t               color_out_o;
  logic                  last_pixel_o;

  line_pixel_stepper dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_pixel_color_i (cfg_pixel_color_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pixel_x_o         (pixel_x_o),
    .pixel_y_o         (pixel_y_o),
    .color_out_o       (color_out_o),
    .last_pixel_o      (last_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  // line state mirrored from the block
  logic    ln_major_y;
  coord_t  ln_org_maj;
  coord_t  ln_org_min;
  coord_t  ln_fin_maj;
  int      ln_maj_len;
  int      ln_min_len;
  coord_t  ln_cur_maj;
  logic    ln_active;
  colour_t colour_reg;

  pixel_t pixel_q[$];

  int  errors;
  int  cycles;
  int  useful_words;
  int  n_starts;
  int  n_steps;
  int  n_ignored;
  int  n_checked;
  int  n_cfg;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;

  task automatic push_pixel(coord_t maj, coord_t mino, logic last);
    pixel_t p;
    p.x      = ln_major_y ? mino : maj;
    p.y      = ln_major_y ? maj : mino;
    p.colour = colour_reg;
    p.last   = last;
    pixel_q.push_back(p);
  endtask

  task automatic rasterise_word(lps_cmd_e cmd, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int     dx;
    int     dy;
    int     a1;
    int     b1;
    int     a2;
    int     b2;
    int     t;
    longint off;
    longint num;
    coord_t mino;
    logic   last;
    if (cmd == CMD_START) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ln_major_y = dy > dx;
      if (ln_major_y) begin
        a1 = sy; b1 = sx; a2 = ey; b2 = ex;
      end else begin
        a1 = sx; b1 = sy; a2 = ex; b2 = ey;
      end
      if (a1 > a2) begin
        t = a1; a1 = a2; a2 = t;
        t = b1; b1 = b2; b2 = t;
      end
      ln_org_maj = coord_t'(a1);
      ln_org_min = coord_t'(b1);
      ln_fin_maj = coord_t'(a2);
      ln_maj_len = a2 - a1;
      ln_min_len = b2 - b1;
      ln_cur_maj = coord_t'(a1);
      ln_active  = ln_maj_len != 0;
      push_pixel(ln_org_maj, ln_org_min, !ln_active);
      n_starts++;
      useful_words++;
    end else if (!ln_active) begin
      n_ignored++;
    end else begin
      ln_cur_maj = ln_cur_maj + 1'b1;
      off  = longint'(ln_cur_maj) - longint'(ln_org_maj);
      num  = 2 * longint'(ln_org_min) * ln_maj_len + 2 * off * ln_min_len + ln_maj_len;
      mino = '0;
      if (ln_maj_len > 0 && num > 0) mino = coord_t'(num / (2 * ln_maj_len));
      last = ln_cur_maj == ln_fin_maj;
      if (last) ln_active = 1'b0;
      push_pixel(ln_cur_maj, mino, last);
      n_steps++;
      useful_words++;
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= 20) $display("MISMATCH %s: expected %0h got %0h (pixel %0d)", what, want, got,
                               n_checked);
  endtask

  always @(posedge clk_i) begin
    pixel_t p;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d pixels still expected", pixel_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel x", 0, pixel_x_o);
      end else begin
        p = pixel_q.pop_front();
        if (pixel_x_o !== p.x) report_mismatch("pixel_x", p.x, pixel_x_o);
        if (pixel_y_o !== p.y) report_mismatch("pixel_y", p.y, pixel_y_o);
        if (color_out_o !== p.colour) report_mismatch("color_out", p.colour, color_out_o);
        if (last_pixel_o !== p.last) report_mismatch("last_pixel", p.last, last_pixel_o);
      end
      n_checked++;
    end
  end

  // receiver: random back-pressure per word
  initial begin
    int stall;
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  task automatic send_word(lps_cmd_e cmd, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do @(posedge clk_i); while (!in_ready_o);
    rasterise_word(cmd, sx, sy, ex, ey);
  endtask

  task automatic step_word();
    send_word(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // hold off the sender until every pixel owed has been taken
  task automatic settle_inputs(int extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_colour(colour_t c);
    cfg_valid_i       <= 1'b1;
    cfg_pixel_color_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    colour_reg = c;
    n_cfg++;
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t base);
    int v;
    v = int'(base) + $urandom_range(0, 24) - 12;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return coord_t'(v);
  endfunction

  task automatic test_points_and_idle_steps();
    send_word(CMD_STEP, '1, '1, '1, '1);
    send_word(CMD_START, '0, '0, '0, '0);
    send_word(CMD_STEP, '0, '0, '0, '0);
    send_word(CMD_START, '1, '1, '1, '1);
  endtask

  task automatic test_long_lines();
    // equal |dx| and |dy|: x stays major
    send_word(CMD_START, '0, '0, '1, '1);
    repeat (2) step_word();
    // restart mid-line, reversed ends, falling minor
    send_word(CMD_START, '1, '0, '0, '1);
    repeat (2) step_word();
    send_word(CMD_START, 12'd7, 12'd4095, 12'd5, 12'd0);
    repeat (2) step_word();
  endtask

  task automatic test_short_lines();
    send_word(CMD_START, 12'd10, 12'd10, 12'd13, 12'd12);
    repeat (4) step_word();
    send_word(CMD_START, 12'd20, 12'd30, 12'd19, 12'd33);
    repeat (3) step_word();
  endtask

  task automatic test_random_lines(colour_t c, bit tx_en, bit rx_en, int target);
    int     goal;
    int     kind;
    int     n;
    coord_t sx;
    coord_t sy;
    settle_inputs(SETTLE_TICKS);
    write_colour(c);
    tx_idle_en = tx_en;
    rx_idle_en = rx_en;
    goal = useful_words + target;
    while (useful_words < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        sx = pick_coord();
        sy = pick_coord();
        send_word(CMD_START, sx, sy, near_coord(sx), near_coord(sy));
        while (ln_active) step_word();
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) step_word();
      end else if (kind < 85) begin
        send_word(CMD_START, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
        n = $urandom_range(1, 8);
        repeat (n) step_word();
      end else if (kind < 97) begin
        send_word(lps_cmd_e'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
      end else begin
        settle_inputs(1);
      end
    end
  endtask

  initial begin
    ln_major_y = 1'b0;
    ln_org_maj = '0;
    ln_org_min = '0;
    ln_fin_maj = '0;
    ln_maj_len = 0;
    ln_min_len = 0;
    ln_cur_maj = '0;
    ln_active  = 1'b0;
    colour_reg = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_points_and_idle_steps();
    test_long_lines();
    test_short_lines();
    test_random_lines('1, 1'b1, 1'b1, 180);
    test_random_lines(colour_t'($urandom), 1'b0, 1'b0, 170);
    test_random_lines('0, 1'b1, 1'b0, 170);
    test_random_lines(colour_t'($urandom), 1'b0, 1'b1, 180);
    settle_inputs(SETTLE_TICKS);

    $display("Ran %0d line starts and %0d pixel steps, %0d steps with no line, %0d colour writes",
             n_starts, n_steps, n_ignored, n_cfg);
    $display("Checked %0d pixels in %0d cycles, %0d mismatches", n_checked, cycles, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_ctrl.sv
rtl/core/lps_dpath.sv
rtl/core/line_pixel_stepper.sv
tb/tb.sv
